/* rtl/core/ffsca_pkg.sv */
// Package of the first-fit split and coalesce allocator.
// Holds the transaction types, status codes, controller states and defaults.
// Depends on nothing.
package ffsca_pkg;

  // Default arena geometry, in granules.
  localparam int unsigned ARENA_UNITS_DEF  = 4096;
  localparam int unsigned HEADER_UNITS_DEF = 1;

  // Status codes of a result transaction.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_NOFIT   = 2'd2;

  // Request modes.
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [11:0] size;
    logic [11:0] address;
  } req_t;

  typedef struct packed {
    logic [11:0] address_out;
    logic [1:0]  status;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_CHK,
    S_ALLOC_SPLIT,
    S_FREE_CHK,
    S_MERGE_START,
    S_MERGE_CHK,
    S_RESP
  } state_e;

endpackage

/* rtl/core/first_fit_split_coalesce_allocator_unit.sv */
// First-fit allocator with block splitting and coalescing on free.
// Top level; one header memory and the walking controller. Uses ffsca_pkg.
//
// The arena of ARENA_UNITS granules is held as back-to-back blocks, each with a
// header entry (payload size and free flag) in one synchronous memory. Every
// request that passes its first checks walks the headers from offset 0 at one
// block per cycle, bounded by the single memory read port. An allocation
// stops at the first free block that fits; a free walks to its block and
// then makes a merge pass over the whole arena that absorbs each free block
// into a free predecessor. One request is handled at a time; a result waits in the output
// register while the next request is taken. No clearing pass is needed after
// reset: only the header at offset 0 is defined at reset.
module first_fit_split_coalesce_allocator_unit
  import ffsca_pkg::*;
#(
  parameter int unsigned ARENA_UNITS  = ARENA_UNITS_DEF,
  parameter int unsigned HEADER_UNITS = HEADER_UNITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  localparam int unsigned AW = $clog2(ARENA_UNITS);
  localparam int unsigned CW = ((AW > 12) ? AW : 12) + 2;
  localparam logic [AW-1:0] RESET_SIZE = AW'(ARENA_UNITS - HEADER_UNITS);
  localparam logic [CW-1:0] ARENA_C    = CW'(ARENA_UNITS);
  localparam logic [CW-1:0] HEADER_C   = CW'(HEADER_UNITS);

  state_e state_q, state_d;

  logic [AW-1:0] pos_q, pos_d;
  logic [AW-1:0] nxpos_q, nxpos_d;
  logic [AW-1:0] cur_size_q, cur_size_d;
  logic          cur_free_q, cur_free_d;
  logic [11:0]   want_q, want_d;
  logic [CW-1:0] target_q, target_d;
  logic [11:0]   res_addr_q, res_addr_d;
  logic [1:0]    res_st_q, res_st_d;
  logic          out_valid_q, out_valid_d;
  rsp_t          out_rsp_q, out_rsp_d;

  // Header memory: {free, size}.
  logic [AW:0]   mem [ARENA_UNITS];
  logic [AW:0]   mem_rd_q;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] wr_addr;
  logic [AW:0]   wr_data;
  logic          rd0_q;
  logic          e0_wr_q;

  logic [AW-1:0] rd_size;
  logic          rd_free;
  logic [CW-1:0] nx_rd;
  logic [CW-1:0] want_c;
  logic [CW-1:0] have_c;
  logic [CW-1:0] rest_pos;
  logic [AW-1:0] merged;
  logic [CW-1:0] nx_merged;
  logic [CW-1:0] nx_next;
  logic [CW-1:0] granted;
  logic          in_acc;

  assign in_acc = in_valid_i && !in_stall_o;

  // Header at offset 0 reads as its reset value until first written.
  assign rd_size = (rd0_q && !e0_wr_q) ? RESET_SIZE : mem_rd_q[AW-1:0];
  assign rd_free = (rd0_q && !e0_wr_q) ? 1'b1 : mem_rd_q[AW];

  assign have_c    = CW'(rd_size);
  assign want_c    = CW'(want_q);
  assign nx_rd     = CW'(pos_q) + HEADER_C + have_c;
  assign rest_pos  = CW'(pos_q) + HEADER_C + want_c;
  assign granted   = CW'(pos_q) + HEADER_C;
  assign merged    = cur_size_q + AW'(HEADER_UNITS) + rd_size;
  assign nx_merged = CW'(pos_q) + HEADER_C + CW'(merged);
  assign nx_next   = CW'(nxpos_q) + HEADER_C + have_c;

  // Memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    mem_rd_q <= mem[rd_addr];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      rd0_q       <= 1'b0;
      e0_wr_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      rd0_q       <= (rd_addr == '0);
      if (we && wr_addr == '0) begin
        e0_wr_q <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    nxpos_q    <= nxpos_d;
    cur_size_q <= cur_size_d;
    cur_free_q <= cur_free_d;
    want_q     <= want_d;
    target_q   <= target_d;
    res_addr_q <= res_addr_d;
    res_st_q   <= res_st_d;
    out_rsp_q  <= out_rsp_d;
  end

  // Next state, memory control and results.
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    nxpos_d     = nxpos_q;
    cur_size_d  = cur_size_q;
    cur_free_d  = cur_free_q;
    want_d      = want_q;
    target_d    = target_q;
    res_addr_d  = res_addr_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q;
    out_rsp_d   = out_rsp_q;
    rd_addr     = '0;
    we          = 1'b0;
    wr_addr     = pos_q;
    wr_data     = {1'b0, rd_size};
    in_stall_o  = (state_q != S_IDLE);

    // The output register drains independently of the walk.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          pos_d      = '0;
          res_addr_d = '0;
          want_d     = in_req_i.size;
          target_d   = CW'(in_req_i.address) - HEADER_C;
          if (in_req_i.mode == MODE_ALLOC) begin
            if (in_req_i.size == '0) begin
              res_st_d = ST_INVALID;
              state_d  = S_RESP;
            end else begin
              state_d = S_ALLOC_CHK;
            end
          end else begin
            if (in_req_i.address == '0 || CW'(in_req_i.address) < HEADER_C) begin
              res_st_d = ST_INVALID;
              state_d  = S_RESP;
            end else begin
              state_d = S_FREE_CHK;
            end
          end
        end
      end
      S_ALLOC_CHK: begin
        if (rd_free && have_c >= want_c) begin
          res_addr_d = granted[11:0];
          res_st_d   = ST_OK;
          we         = 1'b1;
          if (have_c > want_c + HEADER_C) begin
            // Split: the remainder becomes a new free block.
            wr_addr = rest_pos[AW-1:0];
            wr_data = {1'b1, AW'(have_c - want_c - HEADER_C)};
            state_d = S_ALLOC_SPLIT;
          end else begin
            wr_addr = pos_q;
            wr_data = {1'b0, rd_size};
            state_d = S_RESP;
          end
        end else if (nx_rd >= ARENA_C) begin
          res_st_d = ST_NOFIT;
          state_d  = S_RESP;
        end else begin
          pos_d   = nx_rd[AW-1:0];
          rd_addr = nx_rd[AW-1:0];
        end
      end
      S_ALLOC_SPLIT: begin
        we      = 1'b1;
        wr_addr = pos_q;
        wr_data = {1'b0, AW'(want_c)};
        state_d = S_RESP;
      end
      S_FREE_CHK: begin
        if (CW'(pos_q) >= target_q) begin
          if (CW'(pos_q) == target_q) begin
            we      = 1'b1;
            wr_addr = pos_q;
            wr_data = {1'b1, rd_size};
            state_d = S_MERGE_START;
          end else begin
            res_st_d = ST_INVALID;
            state_d  = S_RESP;
          end
        end else if (nx_rd >= ARENA_C) begin
          res_st_d = ST_INVALID;
          state_d  = S_RESP;
        end else begin
          pos_d   = nx_rd[AW-1:0];
          rd_addr = nx_rd[AW-1:0];
        end
      end
      S_MERGE_START: begin
        // Prime the pass with the header at offset 0 as the next block.
        rd_addr    = '0;
        nxpos_d    = '0;
        cur_free_d = 1'b0;
        res_st_d   = ST_OK;
        state_d    = S_MERGE_CHK;
      end
      S_MERGE_CHK: begin
        if (cur_free_q && rd_free) begin
          // Absorb the next block into the current one.
          we         = 1'b1;
          wr_addr    = pos_q;
          wr_data    = {1'b1, merged};
          cur_size_d = merged;
          if (nx_merged >= ARENA_C) begin
            state_d = S_RESP;
          end else begin
            nxpos_d = nx_merged[AW-1:0];
            rd_addr = nx_merged[AW-1:0];
          end
        end else begin
          pos_d      = nxpos_q;
          cur_size_d = rd_size;
          cur_free_d = rd_free;
          if (nx_next >= ARENA_C) begin
            state_d = S_RESP;
          end else begin
            nxpos_d = nx_next[AW-1:0];
            rd_addr = nx_next[AW-1:0];
          end
        end
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d           = 1'b1;
          out_rsp_d.address_out = res_addr_q;
          out_rsp_d.status      = res_st_q;
          state_d               = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // A delivered status is always one of the defined codes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.status == ST_OK || out_rsp_o.status == ST_INVALID ||
                     out_rsp_o.status == ST_NOFIT))
    else $error("undefined status code delivered");

  // The memory is never written while the block is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !we)
    else $error("header memory written while idle");

  // An accepted request always leaves the idle state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != S_IDLE))
    else $error("accepted request did not start");

  // A new result is loaded only into an empty or draining output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && state_q == S_RESP) |=> (state_q == S_RESP))
    else $error("result overwrote a stalled transaction");

endmodule
